FILE: src/sfsn_pkg.sv
// shared types, constants and helpers for the score filter / sort / nms block
// used by sfsn_ctrl, sfsn_dp and score_filter_sort_nms
package sfsn_pkg;

	localparam int MAX_BOXES    = 64;
	localparam int IDX_W        = $clog2(MAX_BOXES);
	localparam int CNT_W        = $clog2(MAX_BOXES + 1);
	localparam int RESULT_LIMIT = 64;
	localparam int EMIT_W       = $clog2(RESULT_LIMIT + 1);

	localparam logic [15:0] SCORE_THR_RST   = 16'd45875;
	localparam logic [15:0] OVERLAP_THR_RST = 16'd19661;

	localparam logic REG_SCORE_THR   = 1'b0;
	localparam logic REG_OVERLAP_THR = 1'b1;

	typedef enum logic [1:0] {
		RD_PREV = 2'd0,
		RD_TAIL = 2'd1,
		RD_I    = 2'd2,
		RD_J    = 2'd3
	} rd_sel_t;

	typedef struct packed {
		logic    load_new;
		logic    ins_begin;
		logic    idx_dec;
		logic    wr_new;
		logic    wr_move;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    i_clr;
		logic    i_inc;
		logic    load_a;
		logic    j_init;
		logic    j_inc;
		logic    mark;
		logic    emit;
		logic    em_end;
	} cmd_t;

	typedef struct packed {
		logic keep;
		logic full;
		logic idx_zero;
		logic rd_ge;
		logic nb_last;
		logic i_end;
		logic i_supp;
		logic j_end;
		logic j_supp;
		logic em_full;
	} stat_t;

	function automatic logic [15:0] span16(input logic [15:0] lo, input logic [15:0] hi);
		span16 = (hi > lo) ? (hi - lo) : 16'd0;
	endfunction

	function automatic logic [15:0] max16(input logic [15:0] a, input logic [15:0] b);
		max16 = (a > b) ? a : b;
	endfunction

	function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
		min16 = (a < b) ? a : b;
	endfunction

endpackage

FILE: src/sfsn_ctrl.sv
// controller state machine: insertion, suppression pass and result emission
// depends on sfsn_pkg
module sfsn_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sfsn_pkg::stat_t stat,
	output sfsn_pkg::cmd_t  cmd
);

	typedef enum logic [17:0] {
		S_IDLE    = 18'h00001,
		S_START   = 18'h00002,
		S_FULLCMP = 18'h00004,
		S_INSRD   = 18'h00008,
		S_INSCMP  = 18'h00010,
		S_FIN     = 18'h00020,
		S_NMSI    = 18'h00040,
		S_NMSLD   = 18'h00080,
		S_NMSAR   = 18'h00100,
		S_NMSJ    = 18'h00200,
		S_PS      = 18'h00400,
		S_PM      = 18'h00800,
		S_PU      = 18'h01000,
		S_PC      = 18'h02000,
		S_PD      = 18'h04000,
		S_EMI     = 18'h08000,
		S_EMTK    = 18'h10000,
		S_EMEND   = 18'h20000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.rd_sel = sfsn_pkg::RD_I;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_new = 1'b1;
					state_d = S_START;
				end
			end
			S_START: begin
				if (!stat.keep) begin
					state_d = S_FIN;
				end else begin
					cmd.ins_begin = 1'b1;
					cmd.rd_en = 1'b1;
					cmd.rd_sel = sfsn_pkg::RD_TAIL;
					state_d = stat.full ? S_FULLCMP : S_INSRD;
				end
			end
			S_FULLCMP: begin
				state_d = stat.rd_ge ? S_FIN : S_INSRD;
			end
			S_INSRD: begin
				if (stat.idx_zero) begin
					cmd.wr_new = 1'b1;
					state_d = S_FIN;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = sfsn_pkg::RD_PREV;
					state_d = S_INSCMP;
				end
			end
			S_INSCMP: begin
				if (stat.rd_ge) begin
					cmd.wr_new = 1'b1;
					state_d = S_FIN;
				end else begin
					cmd.wr_move = 1'b1;
					cmd.idx_dec = 1'b1;
					state_d = S_INSRD;
				end
			end
			S_FIN: begin
				if (stat.nb_last) begin
					cmd.i_clr = 1'b1;
					state_d = S_NMSI;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_NMSI: begin
				if (stat.i_end) begin
					cmd.i_clr = 1'b1;
					state_d = S_EMI;
				end else if (stat.i_supp) begin
					cmd.i_inc = 1'b1;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = sfsn_pkg::RD_I;
					state_d = S_NMSLD;
				end
			end
			S_NMSLD: begin
				cmd.load_a = 1'b1;
				cmd.j_init = 1'b1;
				state_d = S_NMSAR;
			end
			S_NMSAR: state_d = S_NMSJ;
			S_NMSJ: begin
				if (stat.j_end) begin
					cmd.i_inc = 1'b1;
					state_d = S_NMSI;
				end else if (stat.j_supp) begin
					cmd.j_inc = 1'b1;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = sfsn_pkg::RD_J;
					state_d = S_PS;
				end
			end
			S_PS: state_d = S_PM;
			S_PM: state_d = S_PU;
			S_PU: state_d = S_PC;
			S_PC: state_d = S_PD;
			S_PD: begin
				cmd.mark = 1'b1;
				cmd.j_inc = 1'b1;
				state_d = S_NMSJ;
			end
			S_EMI: begin
				if (stat.i_end || stat.em_full) begin
					state_d = S_EMEND;
				end else if (stat.i_supp) begin
					cmd.i_inc = 1'b1;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = sfsn_pkg::RD_I;
					state_d = S_EMTK;
				end
			end
			S_EMTK: begin
				cmd.emit = 1'b1;
				cmd.i_inc = 1'b1;
				state_d = S_EMI;
			end
			S_EMEND: begin
				cmd.em_end = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_no_write_in_nms: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_new || cmd.wr_move) |-> (state_q == S_INSRD || state_q == S_INSCMP))
		else $error("store write outside insertion");
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_START))
		else $error("accepted request not taken");

endmodule

FILE: src/sfsn_dp.sv
// datapath: config registers, sorted box store, overlap arithmetic, result registers
// depends on sfsn_pkg
module sfsn_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic [15:0]     left_x,
	input  logic [15:0]     top_y,
	input  logic [15:0]     right_x,
	input  logic [15:0]     bottom_y,
	input  logic [15:0]     box_score,
	input  logic            frame_end,
	input  sfsn_pkg::cmd_t  cmd,
	output sfsn_pkg::stat_t stat,
	output logic            result_strobe,
	output logic [15:0]     out_left_x,
	output logic [15:0]     out_top_y,
	output logic [15:0]     out_right_x,
	output logic [15:0]     out_bottom_y,
	output logic [15:0]     out_score,
	output logic            box_valid,
	output logic            overflowed,
	output logic            run_last
);

	localparam int IW = sfsn_pkg::IDX_W;
	localparam int CW = sfsn_pkg::CNT_W;
	localparam int EW = sfsn_pkg::EMIT_W;

	logic [15:0] score_thr_q, overlap_thr_q;
	logic [CW-1:0] count_q, i_q, j_q;
	logic [IW-1:0] idx_q;
	logic [EW-1:0] e_q;
	logic ovf_q, pv_q, strobe_q, run_last_q;
	logic [sfsn_pkg::MAX_BOXES-1:0] supp_q;

	logic [63:0] nb_corner_q, rd_corner_q, a_q, pend_corner_q;
	logic [15:0] nb_score_q, rd_score_q, pend_score_q;
	logic nb_last_q;
	logic [63:0] mem_corner [sfsn_pkg::MAX_BOXES];
	logic [15:0] mem_score [sfsn_pkg::MAX_BOXES];
	logic [IW-1:0] raddr;

	logic [31:0] area_a_q;
	logic [15:0] iw_s1, ih_s1, wb_s1, hb_s1;
	logic [31:0] inter_s2, area_b_s2;
	logic [32:0] uni_s3;
	logic [31:0] inter_s3;
	logic [48:0] prod_s4;
	logic [31:0] inter_s4;
	logic hit;

	logic [15:0] o_lx_q, o_ty_q, o_rx_q, o_by_q, o_sc_q;
	logic o_bv_q;

	// status
	assign stat.keep     = (nb_score_q >= score_thr_q);
	assign stat.full     = (count_q == CW'(sfsn_pkg::MAX_BOXES));
	assign stat.idx_zero = (idx_q == '0);
	assign stat.rd_ge    = (rd_score_q >= nb_score_q);
	assign stat.nb_last  = nb_last_q;
	assign stat.i_end    = (i_q >= count_q);
	assign stat.i_supp   = supp_q[i_q[IW-1:0]];
	assign stat.j_end    = (j_q >= count_q);
	assign stat.j_supp   = supp_q[j_q[IW-1:0]];
	assign stat.em_full  = (e_q >= EW'(sfsn_pkg::RESULT_LIMIT));

	always_comb begin
		case (cmd.rd_sel)
			sfsn_pkg::RD_PREV: raddr = idx_q - IW'(1);
			sfsn_pkg::RD_TAIL: raddr = IW'(sfsn_pkg::MAX_BOXES - 1);
			sfsn_pkg::RD_I:    raddr = i_q[IW-1:0];
			sfsn_pkg::RD_J:    raddr = j_q[IW-1:0];
			default:           raddr = '0;
		endcase
	end

	// store
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_corner_q <= mem_corner[raddr];
			rd_score_q  <= mem_score[raddr];
		end
		if (cmd.wr_new) begin
			mem_corner[idx_q] <= nb_corner_q;
			mem_score[idx_q]  <= nb_score_q;
		end else if (cmd.wr_move) begin
			mem_corner[idx_q] <= rd_corner_q;
			mem_score[idx_q]  <= rd_score_q;
		end
	end

	// payload registers and overlap arithmetic
	assign hit = ({inter_s4, 16'd0} > prod_s4[47:0]) && (prod_s4[48] == 1'b0);

	always_ff @(posedge clk) begin
		if (cmd.load_new) begin
			nb_corner_q <= {bottom_y, right_x, top_y, left_x};
			nb_score_q  <= box_score;
			nb_last_q   <= frame_end;
		end
		if (cmd.load_a) a_q <= rd_corner_q;
		area_a_q <= 32'(sfsn_pkg::span16(a_q[15:0], a_q[47:32]))
			* 32'(sfsn_pkg::span16(a_q[31:16], a_q[63:48]));
		iw_s1 <= sfsn_pkg::span16(sfsn_pkg::max16(a_q[15:0], rd_corner_q[15:0]),
			sfsn_pkg::min16(a_q[47:32], rd_corner_q[47:32]));
		ih_s1 <= sfsn_pkg::span16(sfsn_pkg::max16(a_q[31:16], rd_corner_q[31:16]),
			sfsn_pkg::min16(a_q[63:48], rd_corner_q[63:48]));
		wb_s1 <= sfsn_pkg::span16(rd_corner_q[15:0], rd_corner_q[47:32]);
		hb_s1 <= sfsn_pkg::span16(rd_corner_q[31:16], rd_corner_q[63:48]);
		inter_s2  <= 32'(iw_s1) * 32'(ih_s1);
		area_b_s2 <= 32'(wb_s1) * 32'(hb_s1);
		uni_s3    <= 33'(area_a_q) + 33'(area_b_s2) - 33'(inter_s2);
		inter_s3  <= inter_s2;
		prod_s4   <= 49'(overlap_thr_q) * 49'(uni_s3);
		inter_s4  <= inter_s3;
		if (cmd.emit) begin
			pend_corner_q <= rd_corner_q;
			pend_score_q  <= rd_score_q;
		end
		if (cmd.emit || cmd.em_end) begin
			o_lx_q <= pv_q ? pend_corner_q[15:0]  : 16'd0;
			o_ty_q <= pv_q ? pend_corner_q[31:16] : 16'd0;
			o_rx_q <= pv_q ? pend_corner_q[47:32] : 16'd0;
			o_by_q <= pv_q ? pend_corner_q[63:48] : 16'd0;
			o_sc_q <= pv_q ? pend_score_q : 16'd0;
			o_bv_q <= pv_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_thr_q   <= sfsn_pkg::SCORE_THR_RST;
			overlap_thr_q <= sfsn_pkg::OVERLAP_THR_RST;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			idx_q      <= '0;
			i_q        <= '0;
			j_q        <= '0;
			e_q        <= '0;
			pv_q       <= 1'b0;
			supp_q     <= '0;
			strobe_q   <= 1'b0;
			run_last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sfsn_pkg::REG_SCORE_THR:   score_thr_q <= cfg_data;
					sfsn_pkg::REG_OVERLAP_THR: overlap_thr_q <= cfg_data;
					default: ;
				endcase
			end
			strobe_q <= 1'b0;
			if (cmd.ins_begin) begin
				if (stat.full) begin
					ovf_q <= 1'b1;
					idx_q <= IW'(sfsn_pkg::MAX_BOXES - 1);
				end else begin
					idx_q   <= count_q[IW-1:0];
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.idx_dec) idx_q <= idx_q - IW'(1);
			if (cmd.i_clr) begin
				i_q  <= '0;
				e_q  <= '0;
				pv_q <= 1'b0;
			end
			if (cmd.i_inc) i_q <= i_q + CW'(1);
			if (cmd.j_init) j_q <= i_q + CW'(1);
			if (cmd.j_inc) j_q <= j_q + CW'(1);
			if (cmd.mark && hit) supp_q[j_q[IW-1:0]] <= 1'b1;
			if (cmd.emit) begin
				pv_q       <= 1'b1;
				e_q        <= e_q + EW'(1);
				strobe_q   <= pv_q;
				run_last_q <= 1'b0;
			end
			if (cmd.em_end) begin
				strobe_q   <= 1'b1;
				run_last_q <= 1'b1;
				count_q    <= '0;
				ovf_q      <= 1'b0;
				supp_q     <= '0;
				pv_q       <= 1'b0;
			end
		end
	end

	// overflow is sampled with the result, before the frame clear
	logic ovf_out_q;
	always_ff @(posedge clk) begin
		if (cmd.emit || cmd.em_end) ovf_out_q <= ovf_q;
	end

	assign result_strobe = strobe_q;
	assign out_left_x    = o_lx_q;
	assign out_top_y     = o_ty_q;
	assign out_right_x   = o_rx_q;
	assign out_bottom_y  = o_by_q;
	assign out_score     = o_sc_q;
	assign box_valid     = o_bv_q;
	assign overflowed    = ovf_out_q;
	assign run_last      = run_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(sfsn_pkg::MAX_BOXES))
		else $error("store count beyond capacity");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && run_last_q) |-> (count_q == '0 && supp_q == '0))
		else $error("frame state not cleared after last result");
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && !o_bv_q) |-> run_last_q)
		else $error("empty result not marked last");

endmodule

FILE: src/score_filter_sort_nms.sv
// top level: score filter, sorted candidate store and greedy non-maximum suppression
// instantiates sfsn_ctrl and sfsn_dp, uses sfsn_pkg
// a request below threshold is dropped; with a full store a kept one that does not score
// above the tail is dropped, else it goes in with lower entries shifted down one by one
// suppression: each surviving box is checked against every later one not yet suppressed
// emission: each result is output as the next survivor is read, the last one at the end
// one request at a time, taken when busy is low; the receiver cannot stall
// async active-low reset restores the thresholds and empties the store
module score_filter_sort_nms (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] left_x,
	input  logic [15:0] top_y,
	input  logic [15:0] right_x,
	input  logic [15:0] bottom_y,
	input  logic [15:0] box_score,
	input  logic        frame_end,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        result_strobe,
	output logic [15:0] out_left_x,
	output logic [15:0] out_top_y,
	output logic [15:0] out_right_x,
	output logic [15:0] out_bottom_y,
	output logic [15:0] out_score,
	output logic        box_valid,
	output logic        overflowed,
	output logic        run_last
);

	// command and status between controller and datapath
	sfsn_pkg::cmd_t  cmd;
	sfsn_pkg::stat_t stat;

	// sequencer: insertion sort, pairwise suppression, emission
	sfsn_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// store, overlap pipeline and result registers
	sfsn_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.left_x        (left_x),
		.top_y         (top_y),
		.right_x       (right_x),
		.bottom_y      (bottom_y),
		.box_score     (box_score),
		.frame_end     (frame_end),
		.cmd           (cmd),
		.stat          (stat),
		.result_strobe (result_strobe),
		.out_left_x    (out_left_x),
		.out_top_y     (out_top_y),
		.out_right_x   (out_right_x),
		.out_bottom_y  (out_bottom_y),
		.out_score     (out_score),
		.box_valid     (box_valid),
		.overflowed    (overflowed),
		.run_last      (run_last)
	);

endmodule

FILE: tb/sfsn_checker.sv
// checker for score_filter_sort_nms: watches requests, config writes and results
// predicts the kept boxes of each frame and compares them; depends on sfsn_pkg
`timescale 1ns / 1ps

module sfsn_checker (
	input  logic        clk,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] left_x,
	input  logic [15:0] top_y,
	input  logic [15:0] right_x,
	input  logic [15:0] bottom_y,
	input  logic [15:0] box_score,
	input  logic        frame_end,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        result_strobe,
	input  logic [15:0] out_left_x,
	input  logic [15:0] out_top_y,
	input  logic [15:0] out_right_x,
	input  logic [15:0] out_bottom_y,
	input  logic [15:0] out_score,
	input  logic        box_valid,
	input  logic        overflowed,
	input  logic        run_last,
	output int          errors,
	output int          outstanding
);

	typedef struct packed {
		logic [15:0] l, t, r, b, score;
		logic        valid, ovf, last;
	} kept_box_t;

	kept_box_t   kept_q[$];
	kept_box_t   store[$];
	logic        sort_ovf;
	logic [15:0] score_thr;
	logic [15:0] overlap_thr;

	function automatic logic [63:0] len(input logic [15:0] lo, input logic [15:0] hi);
		len = (hi > lo) ? 64'(hi - lo) : 64'd0;
	endfunction

	function automatic logic overlaps(input kept_box_t a, input kept_box_t b,
			input logic [15:0] thr);
		logic [63:0] inter, uni;
		inter = len(a.l > b.l ? a.l : b.l, a.r < b.r ? a.r : b.r) *
			len(a.t > b.t ? a.t : b.t, a.b < b.b ? a.b : b.b);
		uni = len(a.l, a.r) * len(a.t, a.b) + len(b.l, b.r) * len(b.t, b.b) - inter;
		overlaps = (inter << 16) > 64'(thr) * uni;
	endfunction

	// sorted insert, lowest entry drops out when the store is full
	task automatic insert_box(input kept_box_t nb);
		int pos;
		pos = 0;
		while (pos < store.size() && store[pos].score >= nb.score)
			pos++;
		if (store.size() >= sfsn_pkg::MAX_BOXES) begin
			sort_ovf = 1'b1;
			if (pos >= sfsn_pkg::MAX_BOXES)
				return;
			store.delete(store.size() - 1);
		end
		store.insert(pos, nb);
	endtask

	// greedy suppression in score order, then queue the survivors
	task automatic close_frame();
		logic gone[sfsn_pkg::MAX_BOXES];
		int   n;
		kept_box_t e;
		foreach (gone[k])
			gone[k] = 1'b0;
		for (int i = 0; i < store.size(); i++) begin
			if (!gone[i])
				for (int j = i + 1; j < store.size(); j++)
					if (!gone[j] && overlaps(store[i], store[j], overlap_thr))
						gone[j] = 1'b1;
		end
		n = 0;
		for (int i = 0; i < store.size() && n < sfsn_pkg::RESULT_LIMIT; i++) begin
			if (!gone[i]) begin
				e = store[i];
				e.valid = 1'b1;
				e.ovf = sort_ovf;
				e.last = 1'b0;
				kept_q.insert(kept_q.size(), e);
				n++;
			end
		end
		if (n == 0) begin
			e = '0;
			e.ovf = sort_ovf;
			kept_q.insert(kept_q.size(), e);
		end
		kept_q[kept_q.size() - 1].last = 1'b1;
		store.delete();
		sort_ovf = 1'b0;
	endtask

	initial begin
		errors = 0;
		outstanding = 0;
		sort_ovf = 1'b0;
		score_thr = sfsn_pkg::SCORE_THR_RST;
		overlap_thr = sfsn_pkg::OVERLAP_THR_RST;
	end

	always @(posedge clk) begin
		kept_box_t nb, got, exp_box;
		if (cfg_we) begin
			if (cfg_index == sfsn_pkg::REG_SCORE_THR)
				score_thr = cfg_data;
			else
				overlap_thr = cfg_data;
		end
		if (result_strobe) begin
			got = {out_left_x, out_top_y, out_right_x, out_bottom_y, out_score,
				box_valid, overflowed, run_last};
			if (kept_q.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, got);
				errors++;
			end else begin
				exp_box = kept_q[0];
				kept_q.delete(0);
				if (got !== exp_box) begin
					$display("%0t: result mismatch, expected l=%h t=%h r=%h b=%h s=%h v=%b o=%b last=%b",
						$time, exp_box.l, exp_box.t, exp_box.r, exp_box.b, exp_box.score,
						exp_box.valid, exp_box.ovf, exp_box.last);
					$display("%0t:                  actual   l=%h t=%h r=%h b=%h s=%h v=%b o=%b last=%b",
						$time, got.l, got.t, got.r, got.b, got.score,
						got.valid, got.ovf, got.last);
					errors++;
				end
			end
		end
		if (start && !busy) begin
			nb = '0;
			nb.l = left_x;
			nb.t = top_y;
			nb.r = right_x;
			nb.b = bottom_y;
			nb.score = box_score;
			if (box_score >= score_thr)
				insert_box(nb);
			if (frame_end)
				close_frame();
		end
		outstanding = kept_q.size();
	end

endmodule

FILE: tb/score_filter_sort_nms_test.sv
// testbench top for score_filter_sort_nms: clock, reset, requests and config writes
// depends on sfsn_pkg, score_filter_sort_nms and sfsn_checker
`timescale 1ns / 1ps

module score_filter_sort_nms_test;

	logic        clk, arst_n, start, busy, frame_end, cfg_we, cfg_index;
	logic [15:0] left_x, top_y, right_x, bottom_y, box_score, cfg_data;
	logic        result_strobe, box_valid, overflowed, run_last;
	logic [15:0] out_left_x, out_top_y, out_right_x, out_bottom_y, out_score;
	int          errors, outstanding;
	int          cycles;
	logic [15:0] cur_score_thr;

	score_filter_sort_nms i_dut (.*);

	sfsn_checker i_check (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run limit: ends the run with an error report if it hangs
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// gap after a request: mostly none or short, now and then long
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40)
			return 0;
		else if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// one request, held until the block takes it
	task automatic send_box(input logic [15:0] l, t, r, b, s, input logic fe, input int gap);
		left_x    <= l;
		top_y     <= t;
		right_x   <= r;
		bottom_y  <= b;
		box_score <= s;
		frame_end <= fe;
		start     <= 1'b1;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait for every expected result, then let the block settle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == sfsn_pkg::REG_SCORE_THR)
			cur_score_thr = val;
	endtask

	// random box, clustered near a few centers so overlaps are common
	task automatic random_box(input logic fe, input int gap);
		logic [15:0] cx, cy, w, h, s;
		int kind;
		kind = $urandom_range(0, 9);
		cx = 16'(1000 * $urandom_range(1, 3));
		cy = 16'(800 * $urandom_range(1, 3));
		w = 16'($urandom_range(0, 400));
		h = 16'($urandom_range(0, 400));
		if ($urandom_range(0, 3) == 0)
			s = 16'($urandom());
		else if ($urandom_range(0, 2) == 0)
			s = 16'(cur_score_thr + $urandom_range(0, 3));
		else
			s = 16'($urandom_range(cur_score_thr, 65535));
		if (kind == 0)
			send_box(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
				s, fe, gap);
		else if (kind == 1)
			send_box(cx + w, cy + h, cx, cy, s, fe, gap);
		else
			send_box(cx + 16'($urandom_range(0, 60)), cy + 16'($urandom_range(0, 60)),
				cx + w, cy + h, s, fe, gap);
	endtask

	task automatic random_frame(input int n);
		for (int k = 0; k < n; k++)
			random_box(k == n - 1, pick_gap());
	endtask

	initial begin
		start = 1'b0;
		frame_end = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sfsn_pkg::REG_SCORE_THR;
		cfg_data = '0;
		left_x = '0;
		top_y = '0;
		right_x = '0;
		bottom_y = '0;
		box_score = '0;
		cur_score_thr = sfsn_pkg::SCORE_THR_RST;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frame at reset thresholds: extremes, drop, inverted, equal scores
		send_box(16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff, 1'b0, 0);
		send_box(16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'hffff, 1'b0, 0);
		send_box(16'h0010, 16'h0010, 16'h0020, 16'h0020, 16'h0000, 1'b0, 1);
		send_box(16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'd45875, 1'b0, 0);
		send_box(16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'd45875, 1'b0, 0);
		send_box(16'h0180, 16'h0180, 16'h0280, 16'h0280, 16'd45874, 1'b0, 0);
		send_box(16'h5000, 16'h5000, 16'h5000, 16'h6000, 16'hc000, 1'b1, 0);
		// frame with nothing kept gives one empty result
		send_box(16'h1234, 16'h2345, 16'h3456, 16'h4567, 16'h0001, 1'b1, 0);
		drain();

		// everything kept, nothing suppressed except by positive overlap
		write_reg(sfsn_pkg::REG_SCORE_THR, 16'h0000);
		write_reg(sfsn_pkg::REG_OVERLAP_THR, 16'hffff);
		send_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
		send_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 0);
		send_box(16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'h8000, 1'b0, 0);
		send_box(16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'h7fff, 1'b1, 0);
		drain();

		// zero overlap threshold: any intersection suppresses, zero union does not
		write_reg(sfsn_pkg::REG_OVERLAP_THR, 16'h0000);
		send_box(16'h0040, 16'h0040, 16'h0040, 16'h0040, 16'h9000, 1'b0, 0);
		send_box(16'h0040, 16'h0040, 16'h0040, 16'h0040, 16'h9000, 1'b0, 0);
		send_box(16'h0000, 16'h0000, 16'h0300, 16'h0300, 16'h8000, 1'b0, 0);
		send_box(16'h02ff, 16'h02ff, 16'h0400, 16'h0400, 16'h7000, 1'b1, 0);
		drain();

		// overfill the store so the lowest scores drop out, some ties with the tail
		write_reg(sfsn_pkg::REG_OVERLAP_THR, 16'hffff);
		for (int k = 0; k < 66; k++)
			send_box(16'(k * 64), 16'h0000, 16'(k * 64 + 32), 16'h0020,
				16'($urandom_range(0, 20) * 1000), k == 65, pick_gap());
		drain();

		// random frames across several threshold settings, block idle at each write
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_reg(sfsn_pkg::REG_SCORE_THR,
				ph == 0 ? 16'hffff : 16'($urandom_range(0, 60000)));
			write_reg(sfsn_pkg::REG_OVERLAP_THR, ph == 1 ? 16'h0000 : 16'($urandom()));
			random_frame($urandom_range(2, 5));
		end
		drain();
		write_reg(sfsn_pkg::REG_SCORE_THR, sfsn_pkg::SCORE_THR_RST);
		write_reg(sfsn_pkg::REG_OVERLAP_THR, sfsn_pkg::OVERLAP_THR_RST);
		random_frame(8);
		drain();
		repeat (50) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
